// ===== design/wall_eddy_viscosity_damped_core_defines.svh =====
// Assertion macros used by the port checker of the eddy viscosity core.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef WALL_EDDY_VISCOSITY_DAMPED_CORE_DEFINES_SVH
`define WALL_EDDY_VISCOSITY_DAMPED_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WEVD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WEVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wevd_pkg.sv =====
// Shared constants and types of the damped wall-function eddy viscosity core.
// Depends on nothing; used by the core and by the testbench.
package wevd_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_CMU_QUARTER = 1'b0,
    REG_VON_KARMAN  = 1'b1
  } cfg_reg_t;

  localparam logic [31:0] CMU_QUARTER_RST = 32'd588112615;
  localparam logic [31:0] VON_KARMAN_RST  = 32'd440234148;

  // Damping polynomial coefficients and fixed-point unity.
  localparam logic [25:0] C1_COEF = 26'd56294995;
  localparam logic [27:0] C2_COEF = 28'd182958735;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [24:0] YC_MAX  = 25'h100_0000;

  // Saturation limits of the two results.
  localparam logic [31:0] YPLUS_MAX = 32'hFFFF_FFFF;
  localparam logic [39:0] NUT_MAX   = 40'hFF_FFFF_FFFF;

  // Number of Taylor terms after the linear one.
  localparam int unsigned TAY_TERMS = 12;

  // floor(2^32 / i) for the series divisors 2 to 13.
  localparam logic [31:0] RECIP [2:13] = '{
    32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
    32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
    32'd429496729,  32'd390451572,  32'd357913941,  32'd330382099
  };

  // One result transaction.
  typedef struct packed {
    logic        sat;
    logic [31:0] yplus;
    logic [39:0] nut;
  } result_t;

endpackage

// ===== design/wall_eddy_viscosity_damped_core.sv =====
// Channel     | Signals                        | Contents
// in_         | tvalid, tready, tdata[95:0]    | one wall face: y, k, nu
// out_        | tvalid, tready, tdata[71:0], tuser | nut, yplus; saturation flag
// cfg_        | we, index[0:0], wdata[31:0]    | cmu_quarter, von_karman
//
// One face is accepted per cycle while the pipeline is not halted. The pipeline depth
// is set by the 24 square-root steps, 32 divider steps and 36 stages of the exponential.
// Reset (rst_n low, synchronous) clears all valid bits and loads defaults.
// The pipeline advances as one; a two-entry output buffer keeps it moving
// while a result waits, and it halts only when both entries are full.
// Depends on wevd_pkg.
module wall_eddy_viscosity_damped_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // wall_distance, kinetic_energy, laminar_viscosity
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // eddy_viscosity, wall_yplus
  output logic        out_tuser,  // saturated
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Stage payloads.
  typedef struct packed {
    logic        v;
    logic [47:0] rem;
    logic [47:0] res;
    logic [31:0] y;
    logic [31:0] nu;
  } sq_t;

  typedef struct packed {
    logic        v;
    logic [39:0] u;
    logic [31:0] y;
    logic [31:0] nu;
  } u_t;

  typedef struct packed {
    logic        v;
    logic [63:0] lo;
    logic [39:0] hi;
    logic [31:0] nu;
  } pa_t;

  typedef struct packed {
    logic        v;
    logic [53:0] p;
    logic [31:0] nu;
  } pb_t;

  typedef struct packed {
    logic        v;
    logic [53:0] p;
    logic [31:0] nu;
    logic [63:0] ta;
    logic [53:0] tb;
  } ta_t;

  typedef struct packed {
    logic        v;
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] q;
    logic [31:0] nu;
    logic        sat;
    logic [47:0] t1;
  } dv_t;

  typedef struct packed {
    logic        v;
    logic [31:0] yp;
    logic        sat;
    logic [47:0] t1;
    logic [50:0] m1;
    logic [49:0] sq;
  } ea_t;

  typedef struct packed {
    logic        v;
    logic [31:0] yp;
    logic        sat;
    logic [47:0] t1;
    logic [18:0] a1;
    logic [60:0] m2;
  } eb_t;

  typedef struct packed {
    logic        v;
    logic [28:0] r;
    logic [28:0] t;
    logic [57:0] prod;
    logic [25:0] x;
    logic [25:0] q0;
    logic [32:0] pos;
    logic [29:0] neg;
    logic [31:0] yp;
    logic        sat;
    logic [47:0] t1;
  } tay_t;

  typedef struct packed {
    logic        v;
    logic [32:0] d;
    logic [31:0] yp;
    logic        sat;
    logic [47:0] t1;
  } da_t;

  typedef struct packed {
    logic        v;
    logic [64:0] na;
    logic [48:0] nb;
    logic [31:0] yp;
    logic        sat;
  } na_t;

  localparam int unsigned SQ_STEPS  = 24;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned TAY_STG   = 3 * wevd_pkg::TAY_TERMS;

  logic        en;
  logic [31:0] cmu_r;
  logic [31:0] vk_r;

  sq_t  sq_r   [0:SQ_STEPS];
  sq_t  sq_nxt [0:SQ_STEPS];
  u_t   u_r,  u_nxt;
  pa_t  pa_r, pa_nxt;
  pb_t  pb_r, pb_nxt;
  ta_t  ta_r, ta_nxt;
  dv_t  dv_r   [0:DIV_STEPS];
  dv_t  dv_nxt [0:DIV_STEPS];
  ea_t  ea_r, ea_nxt;
  eb_t  eb_r, eb_nxt;
  tay_t tay_r   [0:TAY_STG];
  tay_t tay_nxt [0:TAY_STG];
  da_t  da_r, da_nxt;
  na_t  na_r, na_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmu_r <= wevd_pkg::CMU_QUARTER_RST;
      vk_r  <= wevd_pkg::VON_KARMAN_RST;
    end else if (cfg_we) begin
      unique case (wevd_pkg::cfg_reg_t'(cfg_index))
        wevd_pkg::REG_CMU_QUARTER: cmu_r <= cfg_wdata;
        wevd_pkg::REG_VON_KARMAN:  vk_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = en;

  // Input stage: the radicand is k shifted up by 16 bits.
  always_comb begin
    sq_nxt[0].v   = in_tvalid;
    sq_nxt[0].rem = {in_tdata[63:32], 16'd0};
    sq_nxt[0].res = '0;
    sq_nxt[0].y   = in_tdata[31:0];
    sq_nxt[0].nu  = in_tdata[95:64];
  end

  // Square root, one result bit per stage.
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    localparam logic [47:0] BITV = 48'd1 << (46 - 2 * i);
    logic [47:0] trial;
    always_comb begin
      trial          = sq_r[i].res + BITV;
      sq_nxt[i + 1]  = sq_r[i];
      if (sq_r[i].rem >= trial) begin
        sq_nxt[i + 1].rem = sq_r[i].rem - trial;
        sq_nxt[i + 1].res = (sq_r[i].res >> 1) + BITV;
      end else begin
        sq_nxt[i + 1].res = sq_r[i].res >> 1;
      end
    end
  end

  for (genvar i = 0; i <= SQ_STEPS; i++) begin : g_sq_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[i].v <= 1'b0;
      end else if (en) begin
        sq_r[i] <= sq_nxt[i];
      end
    end
  end

  // Velocity scale u = cmu_quarter * sqrt(k).
  logic [55:0] u_prod;
  always_comb begin
    u_prod    = cmu_r * sq_r[SQ_STEPS].res[23:0];
    u_nxt.v   = sq_r[SQ_STEPS].v;
    u_nxt.u   = u_prod[55:16];
    u_nxt.y   = sq_r[SQ_STEPS].y;
    u_nxt.nu  = sq_r[SQ_STEPS].nu;
  end

  // Partial products of y * u.
  always_comb begin
    pa_nxt.v  = u_r.v;
    pa_nxt.lo = u_r.y * u_r.u[31:0];
    pa_nxt.hi = u_r.y * u_r.u[39:32];
    pa_nxt.nu = u_r.nu;
  end

  // Full product p in Q14.40.
  logic [71:0] p_sum;
  always_comb begin
    p_sum     = {8'd0, pa_r.lo} + {pa_r.hi, 32'd0};
    pb_nxt.v  = pa_r.v;
    pb_nxt.p  = p_sum[71:18];
    pb_nxt.nu = pa_r.nu;
  end

  // Partial products of p * kappa.
  always_comb begin
    ta_nxt.v  = pb_r.v;
    ta_nxt.p  = pb_r.p;
    ta_nxt.nu = pb_r.nu;
    ta_nxt.ta = pb_r.p[31:0] * vk_r;
    ta_nxt.tb = pb_r.p[53:32] * vk_r;
  end

  // Divider set-up: the upper dividend word decides overflow, including nu of zero.
  logic [85:0] t1_sum;
  always_comb begin
    t1_sum        = {22'd0, ta_r.ta} + {ta_r.tb, 32'd0};
    dv_nxt[0].v   = ta_r.v;
    dv_nxt[0].rem = {4'd0, ta_r.p[53:26]};
    dv_nxt[0].num = {ta_r.p[25:0], 6'd0};
    dv_nxt[0].q   = '0;
    dv_nxt[0].nu  = ta_r.nu;
    dv_nxt[0].sat = ({4'd0, ta_r.p[53:26]} >= ta_r.nu);
    dv_nxt[0].t1  = t1_sum[85:38];
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [32:0] rem2;
    logic        ge;
    always_comb begin
      rem2              = {dv_r[j].rem, dv_r[j].num[31]};
      ge                = (rem2 >= {1'b0, dv_r[j].nu});
      dv_nxt[j + 1]     = dv_r[j];
      dv_nxt[j + 1].rem = ge ? 32'(rem2 - {1'b0, dv_r[j].nu}) : rem2[31:0];
      dv_nxt[j + 1].num = {dv_r[j].num[30:0], 1'b0};
      dv_nxt[j + 1].q   = {dv_r[j].q[30:0], ge};
    end
  end

  for (genvar j = 0; j <= DIV_STEPS; j++) begin : g_div_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j].v <= 1'b0;
      end else if (en) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // Clamp yplus for the exponent, form the linear product and square the clamped yplus.
  logic [31:0] yp_div;
  logic [24:0] yc;
  always_comb begin
    yp_div    = dv_r[DIV_STEPS].sat ? wevd_pkg::YPLUS_MAX : dv_r[DIV_STEPS].q;
    yc        = (yp_div > {7'd0, wevd_pkg::YC_MAX}) ? wevd_pkg::YC_MAX : yp_div[24:0];
    ea_nxt.v   = dv_r[DIV_STEPS].v;
    ea_nxt.yp  = yp_div;
    ea_nxt.sat = dv_r[DIV_STEPS].sat;
    ea_nxt.t1  = dv_r[DIV_STEPS].t1;
    ea_nxt.m1  = wevd_pkg::C1_COEF * yc;
    ea_nxt.sq  = yc * yc;
  end

  // Quadratic term of the exponent.
  always_comb begin
    eb_nxt.v   = ea_r.v;
    eb_nxt.yp  = ea_r.yp;
    eb_nxt.sat = ea_r.sat;
    eb_nxt.t1  = ea_r.t1;
    eb_nxt.a1  = ea_r.m1[50:32];
    eb_nxt.m2  = ea_r.sq[48:16] * wevd_pkg::C2_COEF;
  end

  // The clamped exponent stays below 2^29, well under ln 2, so no range
  // reduction is needed: the series runs on the exponent itself.
  logic [29:0] a_sum;
  always_comb begin
    a_sum           = {11'd0, eb_r.a1} + {1'b0, eb_r.m2[60:32]};
    tay_nxt[0]      = '0;
    tay_nxt[0].v    = eb_r.v;
    tay_nxt[0].r    = a_sum[28:0];
    tay_nxt[0].t    = a_sum[28:0];
    tay_nxt[0].pos  = wevd_pkg::ONE_Q32;
    tay_nxt[0].neg  = {1'b0, a_sum[28:0]};
    tay_nxt[0].yp   = eb_r.yp;
    tay_nxt[0].sat  = eb_r.sat;
    tay_nxt[0].t1   = eb_r.t1;
  end

  // Series terms two to thirteen, three stages each: product, reciprocal, correction.
  for (genvar k = 0; k < TAY_STG; k++) begin : g_tay
    localparam int unsigned TERM = 2 + k / 3;
    localparam int unsigned PHASE = k % 3;
    localparam logic [25:0] TERM_C = 26'(TERM);
    logic [57:0] qp;
    logic [25:0] qi;
    logic [25:0] rmd;
    logic [25:0] q;
    always_comb begin
      tay_nxt[k + 1] = tay_r[k];
      qp  = '0;
      qi  = '0;
      rmd = '0;
      q   = '0;
      unique case (PHASE)
        0: begin
          tay_nxt[k + 1].prod = tay_r[k].t * tay_r[k].r;
        end
        1: begin
          tay_nxt[k + 1].x  = tay_r[k].prod[57:32];
          qp                = tay_r[k].prod[57:32] * wevd_pkg::RECIP[TERM];
          tay_nxt[k + 1].q0 = qp[57:32];
        end
        default: begin
          qi  = 26'(tay_r[k].q0 * TERM_C);
          rmd = tay_r[k].x - qi;
          q   = tay_r[k].q0 + {25'd0, (rmd >= TERM_C)};
          tay_nxt[k + 1].t = {3'd0, q};
          if ((TERM % 2) == 1) begin
            tay_nxt[k + 1].neg = tay_r[k].neg + {4'd0, q};
          end else begin
            tay_nxt[k + 1].pos = tay_r[k].pos + {7'd0, q};
          end
        end
      endcase
    end
  end

  for (genvar k = 0; k <= TAY_STG; k++) begin : g_tay_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tay_r[k].v <= 1'b0;
      end else if (en) begin
        tay_r[k] <= tay_nxt[k];
      end
    end
  end

  // Damping factor d = 1 - exp(-a).
  always_comb begin
    da_nxt.v   = tay_r[TAY_STG].v;
    da_nxt.d   = wevd_pkg::ONE_Q32 - (tay_r[TAY_STG].pos - {3'd0, tay_r[TAY_STG].neg});
    da_nxt.yp  = tay_r[TAY_STG].yp;
    da_nxt.sat = tay_r[TAY_STG].sat;
    da_nxt.t1  = tay_r[TAY_STG].t1;
  end

  // Partial products of t1 * d.
  always_comb begin
    na_nxt.v   = da_r.v;
    na_nxt.na  = da_r.t1[31:0] * da_r.d;
    na_nxt.nb  = da_r.t1[47:32] * da_r.d;
    na_nxt.yp  = da_r.yp;
    na_nxt.sat = da_r.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r.v  <= 1'b0;
      pa_r.v <= 1'b0;
      pb_r.v <= 1'b0;
      ta_r.v <= 1'b0;
      ea_r.v <= 1'b0;
      eb_r.v <= 1'b0;
      da_r.v <= 1'b0;
      na_r.v <= 1'b0;
    end else if (en) begin
      u_r  <= u_nxt;
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      ta_r <= ta_nxt;
      ea_r <= ea_nxt;
      eb_r <= eb_nxt;
      da_r <= da_nxt;
      na_r <= na_nxt;
    end
  end

  // Final sum and eddy viscosity saturation.
  logic [80:0]       nut_sum;
  logic              nut_ovf;
  wevd_pkg::result_t res_new;
  always_comb begin
    nut_sum       = {16'd0, na_r.na} + {na_r.nb, 32'd0};
    nut_ovf       = |nut_sum[80:72];
    res_new.nut   = nut_ovf ? wevd_pkg::NUT_MAX : nut_sum[71:32];
    res_new.yplus = na_r.yp;
    res_new.sat   = na_r.sat | nut_ovf;
  end

  // Two-entry output buffer; the pipeline halts only when both entries are held.
  logic [1:0]        cnt_r, cnt_nxt;
  wevd_pkg::result_t slot0_r, slot0_nxt;
  wevd_pkg::result_t slot1_r, slot1_nxt;
  logic              push;
  logic              pop;

  assign en   = (cnt_r != 2'd2) || out_tready;
  assign push = en && na_r.v;
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    priority if (push && pop) begin
      if (cnt_r == 2'd1) begin
        slot0_nxt = res_new;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = res_new;
      end
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = res_new;
      end else begin
        slot1_nxt = res_new;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {slot0_r.yplus, slot0_r.nut};
  assign out_tuser  = slot0_r.sat;

endmodule

// ===== design/wevd_checker.sv =====
// Port checker for the damped wall-function eddy viscosity core, bound to the top level.
// Depends on wall_eddy_viscosity_damped_core_defines.svh.
`include "wall_eddy_viscosity_damped_core_defines.svh"

module wevd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  // A held result keeps its payload until its transaction completes.
  `WEVD_ASSERT_NEXT(a_out_hold,
    out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser),
    "output changed while stalled")

  // The input is refused only while results are waiting and not taken.
  `WEVD_ASSERT_NOW(a_in_stall,
    !in_tready,
    out_tvalid && !out_tready,
    "input refused without output back-pressure")

  // A yplus of zero means no damping, so the eddy viscosity is zero and nothing saturated.
  `WEVD_ASSERT_NOW(a_zero_yplus,
    out_tvalid && (out_tdata[71:40] == 32'd0),
    (out_tdata[39:0] == 40'd0) && !out_tuser,
    "nonzero viscosity for zero yplus")

endmodule

bind wall_eddy_viscosity_damped_core wevd_checker u_wevd_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the damped wall-function eddy viscosity core.
// Streams wall faces and compares every result with a built-in predictor.
// Depends on wevd_pkg and wall_eddy_viscosity_damped_core.
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY     = 103;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        sat;
    logic [31:0] yplus;
    logic [39:0] nut;
  } face_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // wall_distance, kinetic_energy, laminar_viscosity
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // eddy_viscosity, wall_yplus
  logic        out_tuser;  // saturated
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // Predictor copy of the two constants.
  logic [31:0] cmu_q;
  logic [31:0] kappa_q;

  face_result_t expected_q[$];
  int  n_errors;
  int  idle_cycles;
  bit  hold_off;
  bit  gaps_on;

  wall_eddy_viscosity_damped_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Integer square root of a value below 2^48.
  function automatic logic [63:0] root48(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 46;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // exp(-a) in Q0.32 by range reduction and a truncated series.
  function automatic logic [63:0] decay_q32(input logic [63:0] a);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    n = a / 64'd2977044472;
    if (n > 32) return 0;
    r   = a - n * 64'd2977044472;
    t   = 64'h1_0000_0000;
    pos = t;
    neg = 0;
    for (int i = 1; i <= 13; i++) begin
      t = ((t * r) >> 32) / i;
      if (i % 2 == 1) neg += t;
      else pos += t;
    end
    return (pos - neg) >> n;
  endfunction

  // Eddy viscosity, yplus and saturation flag of one wall face.
  function automatic face_result_t wall_face_result(input logic [31:0] y,
                                                    input logic [31:0] k,
                                                    input logic [31:0] nu);
    face_result_t r;
    logic [63:0]  s;
    logic [63:0]  u;
    logic [127:0] p;
    logic [127:0] yp;
    logic [63:0]  yc;
    logic [63:0]  a;
    logic [63:0]  d;
    logic [127:0] t1;
    logic [127:0] nut;
    r.sat = 1'b0;
    s  = root48({16'd0, k, 16'd0});
    u  = ({32'd0, cmu_q} * s) >> 16;
    p  = ({96'd0, y} * {64'd0, u}) >> 18;
    if (nu == 0) begin
      yp    = 32'hFFFF_FFFF;
      r.sat = 1'b1;
    end else begin
      yp = (p << 6) / nu;
      if (yp > 128'hFFFF_FFFF) begin
        yp    = 32'hFFFF_FFFF;
        r.sat = 1'b1;
      end
    end
    yc = (yp > (128'd1 << 24)) ? (64'd1 << 24) : yp[63:0];
    a  = ((64'd56294995 * yc) >> 32) + ((((yc * yc) >> 16) * 64'd182958735) >> 32);
    d  = 64'h1_0000_0000 - decay_q32(a);
    t1 = (p * kappa_q) >> 38;
    nut = (t1 * d) >> 32;
    if (nut > 128'hFF_FFFF_FFFF) begin
      nut   = 40'hFF_FFFF_FFFF;
      r.sat = 1'b1;
    end
    r.nut   = nut[39:0];
    r.yplus = yp[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // Writes one register while the core is idle.
  task automatic write_reg(input wevd_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == wevd_pkg::REG_CMU_QUARTER) cmu_q = val;
    else kappa_q = val;
  endtask

  // Offers one face at a falling edge and holds it until a transaction.
  task automatic send_face(input logic [31:0] y, input logic [31:0] k,
                           input logic [31:0] nu);
    in_tdata  <= {nu, k, y};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(wall_face_result(y, k, nu));
    @(negedge clk);
  endtask

  task automatic pause_face;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word;
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Extremes of each field, zero viscosity and overflow of both results.
  task automatic test_directed;
    logic [31:0] edge_vals [4] = '{32'd0, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF};
    foreach (edge_vals[i]) begin
      send_face(edge_vals[i], edge_vals[i], edge_vals[i]);
      send_face(edge_vals[i], 32'hFFFF_FFFF, 32'd0);
      send_face(32'hFFFF_FFFF, edge_vals[i], 32'd1);
    end
    send_face(32'h1000_0000, 32'h0001_0000, 32'h0000_1000);
    send_face(32'h0100_0000, 32'h0000_8000, 32'h4000_0000);
    send_face(32'h0000_4000, 32'h0010_0000, 32'h0000_0100);
    send_face(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_face(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // Random faces in bursts, mostly physically plausible magnitudes.
  task automatic test_random(input int count);
    logic [31:0] y, k, nu;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        y = rand_word(); k = rand_word(); nu = rand_word();
      end else begin
        y  = $urandom >> $urandom_range(0, 24);
        k  = $urandom >> $urandom_range(0, 24);
        nu = ($urandom >> $urandom_range(4, 30)) | 32'd1;
      end
      send_face(y, k, nu);
      pause_face();
    end
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall.
  task automatic test_backpressure;
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(250);
    join
  endtask

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if (!gaps_on) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 9) < 7);
  end

  // Result checker.
  always @(posedge clk) begin
    face_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[63:0], 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[39:0] !== want.nut)
          report_mismatch("eddy_viscosity", out_tdata[39:0], want.nut);
        if (out_tdata[71:40] !== want.yplus)
          report_mismatch("wall_yplus", out_tdata[71:40], want.yplus);
        if (out_tuser !== want.sat)
          report_mismatch("saturated", out_tuser, want.sat);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("[wall_eddy_viscosity_damped_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_we = 1'b0; cfg_index = wevd_pkg::REG_CMU_QUARTER; cfg_wdata = '0;
    n_errors = 0; idle_cycles = 0; hold_off = 1'b0; gaps_on = 1'b0;
    cmu_q = wevd_pkg::CMU_QUARTER_RST; kappa_q = wevd_pkg::VON_KARMAN_RST;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    drain();
    gaps_on = 1'b1;
    test_random(300);
    drain();
    test_backpressure();
    drain();
    write_reg(wevd_pkg::REG_CMU_QUARTER, 32'hFFFF_FFFF);
    write_reg(wevd_pkg::REG_VON_KARMAN, 32'hFFFF_FFFF);
    test_directed();
    test_random(150);
    drain();
    write_reg(wevd_pkg::REG_CMU_QUARTER, 32'd0);
    write_reg(wevd_pkg::REG_VON_KARMAN, 32'd0);
    test_random(100);
    drain();
    write_reg(wevd_pkg::REG_CMU_QUARTER, $urandom);
    write_reg(wevd_pkg::REG_VON_KARMAN, $urandom);
    test_random(200);
    drain();

    if (n_errors == 0 && expected_q.size() == 0)
      $display("[wall_eddy_viscosity_damped_core] OK");
    else
      $display("[wall_eddy_viscosity_damped_core] ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/wevd_pkg.sv
design/wall_eddy_viscosity_damped_core.sv
design/wevd_checker.sv
bench/testbench.sv
